>>> rtl/core/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the streaming PCHIP tangent core.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Working width of products, quotients' numerators and denominators
    localparam int WW = 104;
    // Width of the serial multiplier's second operand
    localparam int MW = 36;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TIME = 2'd1;
    localparam logic [1:0] ST_CLEARED  = 2'd2;

    localparam logic [1:0] PB_NEWEST = 2'd0;
    localparam logic [1:0] PB_PREV   = 2'd1;
    localparam logic [1:0] PB_BACK2  = 2'd2;

    typedef enum logic [2:0] {
        JK_CLEAR,
        JK_BAD,
        JK_FIRST,
        JK_SECOND,
        JK_GEN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               prev2;
        logic [31:0]        h0;
        logic [31:0]        h1;
        logic signed [32:0] d0;
        logic signed [32:0] d1;
    } t_job;

    typedef struct packed {
        logic [1:0]  points_back;
        logic [31:0] slope;
        logic [1:0]  status;
        logic        last;
    } t_res;

    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        mag33 = d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

>>> rtl/core/pts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_fifo
// Small register FIFO with full and empty flags.
// ----------------------------------------------------------------------------
module pts_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("fifo count over depth");

    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && !rd_en |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("fifo count lost a write");

endmodule

>>> rtl/core/pts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_front
// Accepts samples, keeps the two previous points and the count, and issues
// one classified job per accepted item.
// ----------------------------------------------------------------------------
module pts_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_cmd,
    input  logic [31:0]        i_time_ms,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_q_full,
    output logic               o_full,
    output logic               o_job_wr,
    output pts_pkg::t_job      o_job
);
    logic [31:0] r_t1;
    logic [31:0] r_v1;
    logic [31:0] r_t0;
    logic [31:0] r_v0;
    logic [1:0]  r_cnt;
    logic        acc;
    logic        bad;

    assign o_full   = i_q_full;
    assign acc      = i_push && !i_q_full;
    assign o_job_wr = acc;
    assign bad      = (r_cnt != 2'd0) && (i_time_ms <= r_t1);

    always_comb begin
        if (i_cmd) begin
            o_job.kind = pts_pkg::JK_CLEAR;
        end else if (bad) begin
            o_job.kind = pts_pkg::JK_BAD;
        end else if (r_cnt == 2'd0) begin
            o_job.kind = pts_pkg::JK_FIRST;
        end else if (r_cnt == 2'd1) begin
            o_job.kind = pts_pkg::JK_SECOND;
        end else begin
            o_job.kind = pts_pkg::JK_GEN;
        end
        o_job.prev2 = (r_cnt == 2'd2);
        o_job.h1    = i_time_ms - r_t1;
        o_job.h0    = r_t1 - r_t0;
        o_job.d1    = $signed({i_sample_value[31], i_sample_value})
                    - $signed({r_v1[31], r_v1});
        o_job.d0    = $signed({r_v1[31], r_v1}) - $signed({r_v0[31], r_v0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_t1  <= '0;
            r_v1  <= '0;
            r_t0  <= '0;
            r_v0  <= '0;
        end else if (acc) begin
            if (i_cmd) begin
                r_cnt <= 2'd0;
                r_t1  <= '0;
                r_v1  <= '0;
                r_t0  <= '0;
                r_v0  <= '0;
            end else if (!bad) begin
                // shift the window, saturate the count at three
                r_t0  <= r_t1;
                r_v0  <= r_v1;
                r_t1  <= i_time_ms;
                r_v1  <= i_sample_value;
                r_cnt <= (r_cnt == 2'd3) ? 2'd3 : r_cnt + 2'd1;
            end
        end
    end

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_cmd |=> r_cnt == 2'd0) else $error("clear left samples");

endmodule

>>> rtl/core/pts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_back
// Runs one job at a time: bit-serial multiplier and restoring divider,
// sequenced per tangent, results pushed into the result queue.
// ----------------------------------------------------------------------------
module pts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pts_pkg::t_job i_job,
    input  logic          i_job_empty,
    output logic          o_job_rd,
    output pts_pkg::t_res o_res,
    output logic          o_res_wr,
    input  logic          i_res_full
);
    localparam int WW = pts_pkg::WW;
    localparam int MW = pts_pkg::MW;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_MUL,
        S_EP1, S_EP2, S_EQ1, S_EQ2, S_EDEC, S_EL2, S_ELC, S_ED2, S_EDV,
        S_ICHK, S_IN2, S_ID1, S_ID2, S_ID3, S_ID4, S_IDV,
        S_DIVC, S_DIV, S_RND
    } t_state;

    t_state        r_state;
    t_state        r_ret;
    pts_pkg::t_job r_job;
    logic [1:0]    r_pb;
    logic [31:0]   r_slope;
    logic          r_neg;
    logic [WW-1:0] r_ma;
    logic [MW-1:0] r_mb;
    logic [WW-1:0] r_acc;
    logic [WW-1:0] r_p;
    logic [WW-1:0] r_m;
    logic [WW-1:0] r_num;
    logic [WW-1:0] r_den;
    logic [WW-1:0] r_rem;
    logic [31:0]   r_dn;
    logic [31:0]   r_quo;
    logic [4:0]    r_cnt;

    // endpoint operands; the two-back point swaps the intervals
    logic               swap;
    logic [31:0]        ha;
    logic [31:0]        hb;
    logic signed [32:0] da;
    logic signed [32:0] db;
    logic [32:0]        ma;
    logic [32:0]        mb;
    logic [32:0]        a0;
    logic [32:0]        a1;
    logic [MW-1:0]      hab;
    logic [MW-1:0]      hsum;
    logic [WW-1:0]      da3;
    logic               same_sign;
    logic               int_zero;
    logic [WW:0]        r2;
    logic               r2_ge;
    logic               rnd_up;
    logic [32:0]        q33;
    logic [32:0]        lim33;
    logic [32:0]        qsat;
    logic [1:0]         status;
    logic               last;

    always_comb begin
        swap      = (r_pb == pts_pkg::PB_BACK2);
        ha        = swap ? r_job.h0 : r_job.h1;
        hb        = swap ? r_job.h1 : r_job.h0;
        da        = swap ? r_job.d0 : r_job.d1;
        db        = swap ? r_job.d1 : r_job.d0;
        ma        = pts_pkg::mag33(da);
        mb        = pts_pkg::mag33(db);
        a0        = pts_pkg::mag33(r_job.d0);
        a1        = pts_pkg::mag33(r_job.d1);
        hab       = MW'(ha) + MW'(hb);
        hsum      = MW'(r_job.h0) + MW'(r_job.h1);
        da3       = WW'(ma) + WW'({ma, 1'b0});
        same_sign = (db != '0) && (da[32] == db[32]);
        int_zero  = (r_job.d0 == '0) || (r_job.d1 == '0) || (r_job.d0[32] != r_job.d1[32]);
        r2        = {r_rem, r_dn[31]};
        r2_ge     = r2 >= {1'b0, r_den};
        rnd_up    = {r_rem, 1'b0} >= {1'b0, r_den};
        q33       = {1'b0, r_quo} + 33'(rnd_up);
        lim33     = r_neg ? 33'h080000000 : 33'h07FFFFFFF;
        qsat      = (q33 > lim33) ? lim33 : q33;
    end

    always_comb begin
        case (r_job.kind)
            pts_pkg::JK_CLEAR: status = pts_pkg::ST_CLEARED;
            pts_pkg::JK_BAD:   status = pts_pkg::ST_BAD_TIME;
            default:           status = pts_pkg::ST_OK;
        endcase
        case (r_job.kind)
            pts_pkg::JK_SECOND: last = (r_pb == pts_pkg::PB_PREV);
            pts_pkg::JK_GEN:    last = (r_pb == pts_pkg::PB_BACK2)
                                    || ((r_pb == pts_pkg::PB_PREV) && !r_job.prev2);
            default:            last = 1'b1;
        endcase
    end

    assign o_job_rd          = (r_state == S_IDLE) && !i_job_empty;
    assign o_res_wr          = (r_state == S_EMIT);
    assign o_res.points_back = r_pb;
    assign o_res.slope       = r_slope;
    assign o_res.status      = status;
    assign o_res.last        = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pb    <= pts_pkg::PB_NEWEST;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_job   <= i_job;
                        r_pb    <= pts_pkg::PB_NEWEST;
                        r_slope <= '0;
                        case (i_job.kind)
                            pts_pkg::JK_SECOND: begin
                                r_num   <= WW'(pts_pkg::mag33(i_job.d1));
                                r_den   <= WW'(i_job.h1);
                                r_neg   <= i_job.d1[32];
                                r_state <= S_DIVC;
                            end
                            pts_pkg::JK_GEN: r_state <= S_EP1;
                            default:         r_state <= S_EMIT;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) begin
                        case (r_job.kind)
                            pts_pkg::JK_SECOND: begin
                                if (r_pb == pts_pkg::PB_NEWEST) begin
                                    r_pb <= pts_pkg::PB_PREV;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            pts_pkg::JK_GEN: begin
                                if (r_pb == pts_pkg::PB_NEWEST) begin
                                    r_pb    <= pts_pkg::PB_PREV;
                                    r_state <= S_ICHK;
                                end else if (r_pb == pts_pkg::PB_PREV && r_job.prev2) begin
                                    r_pb    <= pts_pkg::PB_BACK2;
                                    r_state <= S_EP1;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        r_state <= r_ret;
                    end else begin
                        if (r_mb[0]) begin
                            r_acc <= r_acc + r_ma;
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                // endpoint tangent
                S_EP1: begin
                    r_neg <= da[32];
                    if (da == '0) begin
                        r_slope <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_ma    <= WW'({ha, 1'b0}) + WW'(hb);
                        r_mb    <= MW'(ma);
                        r_acc   <= '0;
                        r_ret   <= S_EP2;
                        r_state <= S_MUL;
                    end
                end
                S_EP2: begin
                    r_ma    <= r_acc;
                    r_mb    <= MW'(hb);
                    r_acc   <= '0;
                    r_ret   <= S_EQ1;
                    r_state <= S_MUL;
                end
                S_EQ1: begin
                    r_p     <= r_acc;
                    r_ma    <= WW'(ha);
                    r_mb    <= MW'(ha);
                    r_acc   <= '0;
                    r_ret   <= S_EQ2;
                    r_state <= S_MUL;
                end
                S_EQ2: begin
                    r_ma    <= r_acc;
                    r_mb    <= MW'(mb);
                    r_acc   <= '0;
                    r_ret   <= S_EDEC;
                    r_state <= S_MUL;
                end
                S_EDEC: begin
                    if (same_sign) begin
                        if (r_p <= r_acc) begin
                            r_slope <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_m     <= r_p - r_acc;
                            r_ma    <= WW'(ha);
                            r_mb    <= MW'(hb);
                            r_acc   <= '0;
                            r_ret   <= S_ED2;
                            r_state <= S_MUL;
                        end
                    end else begin
                        // opposite or flat neighbouring secant: limit against three times the secant
                        r_m     <= r_p + r_acc;
                        r_ma    <= da3;
                        r_mb    <= MW'(hb);
                        r_acc   <= '0;
                        r_ret   <= S_EL2;
                        r_state <= S_MUL;
                    end
                end
                S_EL2: begin
                    r_ma    <= r_acc;
                    r_mb    <= hab;
                    r_acc   <= '0;
                    r_ret   <= S_ELC;
                    r_state <= S_MUL;
                end
                S_ELC: begin
                    if (r_m > r_acc) begin
                        r_num   <= da3;
                        r_den   <= WW'(ha);
                        r_state <= S_DIVC;
                    end else begin
                        r_ma    <= WW'(ha);
                        r_mb    <= MW'(hb);
                        r_acc   <= '0;
                        r_ret   <= S_ED2;
                        r_state <= S_MUL;
                    end
                end
                S_ED2: begin
                    r_ma    <= r_acc;
                    r_mb    <= hab;
                    r_acc   <= '0;
                    r_ret   <= S_EDV;
                    r_state <= S_MUL;
                end
                S_EDV: begin
                    r_num   <= r_m;
                    r_den   <= r_acc;
                    r_state <= S_DIVC;
                end
                // interior tangent, weighted harmonic mean
                S_ICHK: begin
                    r_neg <= r_job.d0[32];
                    if (int_zero) begin
                        r_slope <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_ma    <= WW'(a0);
                        r_mb    <= MW'(a1);
                        r_acc   <= '0;
                        r_ret   <= S_IN2;
                        r_state <= S_MUL;
                    end
                end
                S_IN2: begin
                    r_ma    <= r_acc;
                    r_mb    <= hsum + (hsum << 1);
                    r_acc   <= '0;
                    r_ret   <= S_ID1;
                    r_state <= S_MUL;
                end
                S_ID1: begin
                    r_m     <= r_acc;
                    r_ma    <= WW'({r_job.h1, 1'b0}) + WW'(r_job.h0);
                    r_mb    <= MW'(r_job.h0);
                    r_acc   <= '0;
                    r_ret   <= S_ID2;
                    r_state <= S_MUL;
                end
                S_ID2: begin
                    r_ma    <= r_acc;
                    r_mb    <= MW'(a1);
                    r_acc   <= '0;
                    r_ret   <= S_ID3;
                    r_state <= S_MUL;
                end
                S_ID3: begin
                    r_p     <= r_acc;
                    r_ma    <= WW'(r_job.h1) + WW'({r_job.h0, 1'b0});
                    r_mb    <= MW'(r_job.h1);
                    r_acc   <= '0;
                    r_ret   <= S_ID4;
                    r_state <= S_MUL;
                end
                S_ID4: begin
                    r_ma    <= r_acc;
                    r_mb    <= MW'(a0);
                    r_acc   <= '0;
                    r_ret   <= S_IDV;
                    r_state <= S_MUL;
                end
                S_IDV: begin
                    r_num   <= r_m;
                    r_den   <= r_p + r_acc;
                    r_state <= S_DIVC;
                end
                // quotient of 2^32 or more saturates at once
                S_DIVC: begin
                    if (WW'(r_num[WW-1:32]) >= r_den) begin
                        r_slope <= r_neg ? 32'h80000000 : 32'h7FFFFFFF;
                        r_state <= S_EMIT;
                    end else begin
                        r_rem   <= WW'(r_num[WW-1:32]);
                        r_dn    <= r_num[31:0];
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= r2_ge ? WW'(r2 - {1'b0, r_den}) : r2[WW-1:0];
                    r_quo <= {r_quo[30:0], r2_ge};
                    r_dn  <= r_dn << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_slope <= r_neg ? 32'(-qsat) : qsat[31:0];
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den) else $error("remainder not below divisor");

    a_simple_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_job.kind != pts_pkg::JK_GEN
        && r_job.kind != pts_pkg::JK_SECOND |-> r_slope == '0)
        else $error("nonzero slope on status result");

endmodule

>>> rtl/core/pchip_tangent_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pchip_tangent_stream_core
// Streaming PCHIP tangents for time-stamped Q16.16 samples.
// ----------------------------------------------------------------------------
// Input side is a queue: drive i_cmd, i_time_ms, i_sample_value with push;
// the sample transfers when push is high and full is low. Results come out
// of a four-entry queue: while empty is low the oldest result sits on
// o_points_back, o_slope_q, o_status, o_last_of_run and transfers on pop.
// The front updates the sample window as the item transfers and queues a
// job (two entries); the back works one job at a time. A clear, a rejected
// time or a first sample goes straight to the result queue. A second sample
// takes one division; a later one takes up to 22 products and 3 divisions,
// fewer where secants are flat or change sign, on the shared bit-serial
// multiplier (one bit of the second operand per cycle) and the 32-step
// restoring divider.
// When the receiver stalls the result queue fills, the back waits, and then
// the job queue fills and full rises; nothing is dropped. Reset empties both
// queues and clears the window and count.
// ----------------------------------------------------------------------------
module pchip_tangent_stream_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_cmd,
    input  logic [31:0]        i_time_ms,
    input  logic signed [31:0] i_sample_value,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_points_back,
    output logic signed [31:0] o_slope_q,
    output logic [1:0]         o_status,
    output logic               o_last_of_run
);
    localparam int JW = $bits(pts_pkg::t_job);
    localparam int RW = $bits(pts_pkg::t_res);

    pts_pkg::t_job job_in;
    pts_pkg::t_job job_out;
    pts_pkg::t_res res_in;
    pts_pkg::t_res res_out;
    logic          job_wr;
    logic          job_full;
    logic          job_rd;
    logic          job_empty;
    logic          res_wr;
    logic          res_full;

    pts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_cmd          (i_cmd),
        .i_time_ms      (i_time_ms),
        .i_sample_value (i_sample_value),
        .i_q_full       (job_full),
        .o_full         (full),
        .o_job_wr       (job_wr),
        .o_job          (job_in)
    );

    pts_fifo #(.W(JW), .DEPTH(2)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_wdata (job_in),
        .o_full  (job_full),
        .i_rd    (job_rd),
        .o_rdata (job_out),
        .o_empty (job_empty)
    );

    pts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_rd    (job_rd),
        .o_res       (res_in),
        .o_res_wr    (res_wr),
        .i_res_full  (res_full)
    );

    pts_fifo #(.W(RW), .DEPTH(4)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_points_back = res_out.points_back;
    assign o_slope_q     = res_out.slope;
    assign o_status      = res_out.status;
    assign o_last_of_run = res_out.last;

endmodule

>>> bench/pts_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_tb_pkg
// Command codes shared by the stimulus and the checker of the tangent core.
// ----------------------------------------------------------------------------
package pts_tb_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

endpackage

>>> bench/pts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// Watches both queue sides of the tangent core, predicts the PCHIP tangents
// of every accepted sample with exact wide arithmetic and compares each popped
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
module pts_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic               i_cmd,
    input  logic [31:0]        i_time_ms,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [1:0]         i_points_back,
    input  logic signed [31:0] i_slope_q,
    input  logic [1:0]         i_status,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef logic [127:0] u128_t;

    pts_pkg::t_res tangent_q[$];
    logic [31:0]   win_time[2];
    longint        win_val[2];
    int            held;

    initial begin
        win_time = '{default: '0};
        win_val  = '{default: 0};
        held     = 0;
    end

    assign o_pending = tangent_q.size();

    function automatic logic [63:0] mag(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // rounded half away from zero, then saturated to 32 bits
    function automatic logic [31:0] rdiv(input u128_t n, input u128_t d, input bit neg);
        u128_t q;
        u128_t r;
        u128_t lim;
        q   = n / d;
        r   = n % d;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if ((r << 1) >= d) q = q + 1;
        if (q > lim) q = lim;
        return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    function automatic logic [31:0] interior_slope(input logic [63:0] h0, input logic [63:0] h1,
                                                   input longint d0, input longint d1);
        u128_t num;
        u128_t den;
        if (d0 == 0 || d1 == 0 || ((d0 < 0) != (d1 < 0))) return '0;
        num = u128_t'(mag(d0)) * u128_t'(mag(d1)) * u128_t'(3 * (h0 + h1));
        den = u128_t'(2 * h1 + h0) * u128_t'(h0) * u128_t'(mag(d1))
            + u128_t'(h1 + 2 * h0) * u128_t'(h1) * u128_t'(mag(d0));
        return rdiv(num, den, d0 < 0);
    endfunction

    // ha spans the endpoint, hb the neighboring interval
    function automatic logic [31:0] endpoint_slope(input logic [63:0] ha, input logic [63:0] hb,
                                                   input longint da, input longint db);
        u128_t p;
        u128_t q;
        u128_t m;
        u128_t lim;
        bit    sa;
        bit    sb;
        bit    neg;
        bit    diverge;
        sa = da < 0;
        sb = db < 0;
        if (da == 0) return '0;
        p = u128_t'(2 * ha + hb) * u128_t'(mag(da)) * u128_t'(hb);
        q = u128_t'(ha) * u128_t'(ha) * u128_t'(mag(db));
        diverge = (db == 0) || (sa != sb);
        if (diverge) begin
            m   = p + q;
            neg = sa;
        end else begin
            if (p == q) return '0;
            m   = p > q ? p - q : q - p;
            neg = p > q ? sa : !sa;
        end
        if (neg != sa) return '0;
        if (diverge) begin
            lim = u128_t'(3 * mag(da)) * u128_t'(hb) * u128_t'(ha + hb);
            if (m > lim) return rdiv(u128_t'(3 * mag(da)), u128_t'(ha), sa);
        end
        return rdiv(m, u128_t'(ha) * u128_t'(hb) * u128_t'(ha + hb), neg);
    endfunction

    function automatic pts_pkg::t_res mk(input logic [1:0] pb, input logic [31:0] s,
                                         input logic [1:0] st, input logic last);
        pts_pkg::t_res r;
        r.points_back = pb;
        r.slope       = s;
        r.status      = st;
        r.last        = last;
        return r;
    endfunction

    task automatic predict_tangents(input logic c, input logic [31:0] t, input longint v);
        logic [63:0] h0;
        logic [63:0] h1;
        longint      d0;
        longint      d1;
        int          prev;
        logic [31:0] s;
        prev = held;
        if (c == pts_tb_pkg::CMD_CLEAR) begin
            win_time = '{default: '0};
            win_val  = '{default: 0};
            held     = 0;
            tangent_q.push_back(mk(pts_pkg::PB_NEWEST, '0, pts_pkg::ST_CLEARED, 1'b1));
            return;
        end
        if (prev > 0 && t <= win_time[0]) begin
            tangent_q.push_back(mk(pts_pkg::PB_NEWEST, '0, pts_pkg::ST_BAD_TIME, 1'b1));
            return;
        end
        h1 = 64'(t) - 64'(win_time[0]);
        h0 = 64'(win_time[0]) - 64'(win_time[1]);
        d1 = v - win_val[0];
        d0 = win_val[0] - win_val[1];
        win_time[1] = win_time[0];
        win_val[1]  = win_val[0];
        win_time[0] = t;
        win_val[0]  = v;
        held = prev >= 3 ? 3 : prev + 1;
        if (prev == 0) begin
            tangent_q.push_back(mk(pts_pkg::PB_NEWEST, '0, pts_pkg::ST_OK, 1'b1));
        end else if (prev == 1) begin
            s = rdiv(u128_t'(mag(d1)), u128_t'(h1), d1 < 0);
            tangent_q.push_back(mk(pts_pkg::PB_NEWEST, s, pts_pkg::ST_OK, 1'b0));
            tangent_q.push_back(mk(pts_pkg::PB_PREV, s, pts_pkg::ST_OK, 1'b1));
        end else begin
            tangent_q.push_back(mk(pts_pkg::PB_NEWEST, endpoint_slope(h1, h0, d1, d0),
                                   pts_pkg::ST_OK, 1'b0));
            tangent_q.push_back(mk(pts_pkg::PB_PREV, interior_slope(h0, h1, d0, d1),
                                   pts_pkg::ST_OK, prev == 2 ? 1'b0 : 1'b1));
            if (prev == 2)
                tangent_q.push_back(mk(pts_pkg::PB_BACK2, endpoint_slope(h0, h1, d0, d1),
                                       pts_pkg::ST_OK, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        pts_pkg::t_res e;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_push && !i_full)
                predict_tangents(i_cmd, i_time_ms, longint'(i_sample_value));
            if (i_pop && !i_empty) begin
                if (tangent_q.size() == 0) begin
                    $error("result transfer with nothing expected: pb=%0d slope=%0d st=%0d",
                           i_points_back, i_slope_q, i_status);
                    errs++;
                end else begin
                    e = tangent_q.pop_front();
                    if (i_points_back !== e.points_back) begin
                        $error("points_back: expected %0d, got %0d", e.points_back, i_points_back);
                        errs++;
                    end
                    if (i_slope_q !== e.slope) begin
                        $error("slope_q: expected %0d, got %0d",
                               $signed(e.slope), i_slope_q);
                        errs++;
                    end
                    if (i_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, i_status);
                        errs++;
                    end
                    if (i_last_of_run !== e.last) begin
                        $error("last_of_run: expected %0d, got %0d", e.last, i_last_of_run);
                        errs++;
                    end
                end
            end
            if (errs != 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the tangent core with directed and random sample series, bursty
// pushes and a stalling receiver, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_cmd;
    logic [31:0]        i_time_ms;
    logic signed [31:0] i_sample_value;
    logic               empty;
    logic               pop;
    logic [1:0]         o_points_back;
    logic signed [31:0] o_slope_q;
    logic [1:0]         o_status;
    logic               o_last_of_run;
    int                 fail_count;
    int                 pending;

    logic [31:0]        last_time;
    logic signed [31:0] last_val;
    bit                 have_sample;
    bit                 hold_req;
    int                 burst_left;

    pchip_tangent_stream_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_cmd          (i_cmd),
        .i_time_ms      (i_time_ms),
        .i_sample_value (i_sample_value),
        .empty          (empty),
        .pop            (pop),
        .o_points_back  (o_points_back),
        .o_slope_q      (o_slope_q),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

    pts_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_cmd          (i_cmd),
        .i_time_ms      (i_time_ms),
        .i_sample_value (i_sample_value),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_points_back  (o_points_back),
        .i_slope_q      (o_slope_q),
        .i_status       (o_status),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int left;
        pop = 1'b0;
        mode = 0;
        left = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (4000) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ($urandom_range(0, 9) == 0);
                default: pop <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge i_clk);
        end
    end

    // offer one item and hold it until it transfers; push stays high after
    task automatic send_item(input logic c, input logic [31:0] t, input logic signed [31:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        push           <= 1'b1;
        i_cmd          <= c;
        i_time_ms      <= t;
        i_sample_value <= v;
        do @(posedge i_clk); while (full);
        if (c == pts_tb_pkg::CMD_CLEAR) begin
            have_sample = 1'b0;
        end else if (!have_sample || t > last_time) begin
            have_sample = 1'b1;
            last_time   = t;
            last_val    = v;
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4, 5: return $signed($urandom);
            default: return last_val + $signed(32'($urandom_range(0, 8192)) - 32'sd4096);
        endcase
    endfunction

    initial begin
        logic [31:0] t;
        logic [31:0] room;
        int          n;
        push           = 1'b0;
        i_cmd          = pts_tb_pkg::CMD_APPEND;
        i_time_ms      = '0;
        i_sample_value = '0;
        i_rst_n        = 1'b0;
        hold_req       = 1'b0;
        have_sample    = 1'b0;
        last_time      = '0;
        last_val       = '0;
        burst_left     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, bad times, flat and sign-change secants, limiter
        send_item(pts_tb_pkg::CMD_CLEAR, '0, '0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd0, 32'sh7FFF_FFFF);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd0, 32'sd5);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd1, 32'sh8000_0000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd3, 32'sh8000_0000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd7, 32'sd0);
        send_item(pts_tb_pkg::CMD_CLEAR, '0, '0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd10, 32'sd0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd20, 32'sd0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd30, 32'sd100);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd40, 32'sd50);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd45, -32'sd50);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd50, -32'sd1000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd49, 32'sd3);
        send_item(pts_tb_pkg::CMD_CLEAR, '0, '0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd100, 32'sd1000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd101, 32'sd200000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd300, 32'sd200100);
        send_item(pts_tb_pkg::CMD_APPEND, 32'd301, 32'sd9000000);
        send_item(pts_tb_pkg::CMD_CLEAR, '0, '0);
        send_item(pts_tb_pkg::CMD_APPEND, 32'h8000_0000, -32'sd7);
        send_item(pts_tb_pkg::CMD_APPEND, 32'hFFFF_FFFE, 32'sh7FFF_0000);
        send_item(pts_tb_pkg::CMD_APPEND, 32'hFFFF_FFFF, 32'sh8000_0001);

        // random series: mostly well-formed runs, some clears and bad times
        for (n = 0; n < 410; n++) begin
            if (n == 60) hold_req = 1'b1;
            room = 32'hFFFF_FFFF - last_time;
            if ($urandom_range(0, 32) == 0 || (have_sample && room == 0)) begin
                send_item(pts_tb_pkg::CMD_CLEAR, $urandom, $signed($urandom));
            end else if (have_sample && $urandom_range(0, 19) == 0) begin
                t = last_time - $urandom_range(0, last_time > 1000 ? 1000 : last_time);
                send_item(pts_tb_pkg::CMD_APPEND, t, pick_value());
            end else if (!have_sample) begin
                t = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 5000);
                send_item(pts_tb_pkg::CMD_APPEND, t, pick_value());
            end else begin
                case ($urandom_range(0, 19))
                    0: t = last_time + $urandom_range(1, room);
                    1, 2, 3: t = last_time + $urandom_range(1, room > 65535 ? 65535 : room);
                    default: t = last_time + $urandom_range(1, room > 64 ? 64 : room);
                endcase
                send_item(pts_tb_pkg::CMD_APPEND, t, pick_value());
            end
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
